[sv/rti_pkg.sv]
`timescale 1ns / 1ps

package rti_pkg;

    localparam int COORD_W    = 24;   // Q12.12 coordinate
    localparam int S_W        = 25;   // origin minus vertex
    localparam int MB_W       = 26;   // second multiplier operand
    localparam int PROD_W     = S_W + MB_W;
    localparam int WIDE_W     = 50;   // cross product component
    localparam int ACC_W      = 80;   // dot product accumulator
    localparam int ID_W       = 16;
    localparam int LIM_W      = 32;
    localparam int EPS_W      = 48;
    localparam int UV_W       = 17;
    localparam int CNT_W      = 5;
    localparam int IN_W       = 240;
    localparam int OUT_W      = 120;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS      = 4'd7;

    localparam logic [EPS_W-1:0] EPS_RESET = 48'd687;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_PV    = 13'b0000000000010,
        ST_Q     = 13'b0000000000100,
        ST_DET   = 13'b0000000001000,
        ST_UN    = 13'b0000000010000,
        ST_VN    = 13'b0000000100000,
        ST_TN    = 13'b0000001000000,
        ST_ABS   = 13'b0000010000000,
        ST_CHECK = 13'b0000100000000,
        ST_DIV_T = 13'b0001000000000,
        ST_DIV_U = 13'b0010000000000,
        ST_DIV_V = 13'b0100000000000,
        ST_DONE  = 13'b1000000000000
    } state_t;

endpackage

[sv/ray_triangle_intersect.sv]
`timescale 1ns / 1ps

// Channel   Dir  Signals                                  Contents
// s_        in   s_tvalid s_tready s_tdata[239:0]         one triangle
// m_        out  m_tvalid m_tready m_tdata[119:0]         one test result
// cfg_      in   cfg_valid cfg_ready cfg_index cfg_data   ray registers
//
// One shared 25x26 MAC computes both cross products and four dot products,
// followed by the det sign fix and the checks. A triangle that fails the
// checks goes straight to the output; one that reaches the divider runs 32
// restoring steps for t, and a hit 2x17 more for u and v. s_tready is high
// only while idle.
// A finished item waits in the output register; the next one may run.
// aresetn is synchronous; it restores register defaults and the limit.

module ray_triangle_intersect (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // new_ray, p1_x, p1_y, p1_z, edge1_x, edge1_y, edge1_z,
    // edge2_x, edge2_y, edge2_z, tri_id, zero pad
    input  logic [rti_pkg::IN_W-1:0]        s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hit, t_hit, u_bary, v_bary, hit_id, limit_now, zero pad
    output logic [rti_pkg::OUT_W-1:0]       m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rti_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rti_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rti_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [COORD_W-1:0] o_reg [3], o_next [3];
    logic signed [COORD_W-1:0] d_reg [3], d_next [3];
    logic [LIM_W-1:0] lim_start_reg, lim_start_next;
    logic [EPS_W-1:0] eps_reg, eps_next;
    logic [LIM_W-1:0] nearest_reg, nearest_next;
    logic m_valid_reg, m_valid_next;

    logic signed [COORD_W-1:0] e1_reg [3], e1_next [3];
    logic signed [COORD_W-1:0] e2_reg [3], e2_next [3];
    logic signed [S_W-1:0] s_reg [3], s_next [3];
    logic signed [WIDE_W-1:0] pv_reg [3], pv_next [3];
    logic signed [WIDE_W-1:0] q_reg [3], q_next [3];
    logic [ID_W-1:0] id_reg, id_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] det_reg, det_next;
    logic [ACC_W-1:0] un_reg, un_next;
    logic [ACC_W-1:0] vn_reg, vn_next;
    logic [ACC_W-1:0] tn_reg, tn_next;
    logic [ACC_W-1:0] rem_reg, rem_next;
    logic [LIM_W-1:0] num_reg, num_next;
    logic [LIM_W-1:0] quo_reg, quo_next;
    logic hit_reg, hit_next;
    logic [LIM_W-1:0] t_reg, t_next;
    logic [UV_W-1:0] u_reg, u_next;
    logic [UV_W-1:0] v_reg, v_next;
    logic [OUT_W-1:0] m_data_reg, m_data_next;

    // MAC datapath
    logic [1:0] comp, c1, c2, ia, ib;
    logic term, first, last, shift_hi, neg;
    logic signed [S_W-1:0] a_op;
    logic signed [MB_W-1:0] b_op;
    logic signed [WIDE_W-1:0] wsel;
    logic signed [PROD_W-1:0] prod;
    logic [ACC_W-1:0] prod_ext, mac_term, acc_base;

    // divider step
    logic [ACC_W:0] div_shift, div_trial;
    logic div_ge;
    logic [ACC_W-1:0] rem_step;
    logic [LIM_W-1:0] quo_step;

    // checks
    logic [ACC_W:0] uv_sum;
    logic [ACC_W+15:0] det_sh;
    logic checks_ok;

    logic in_acc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign in_acc    = s_tvalid && s_tready;

    assign comp     = cnt_reg[2:1];
    assign term     = cnt_reg[0];
    // cross components restart on every pair, dot products once per six terms
    assign first    = (cnt_reg == CNT_W'(0)) ||
                      (!term && (state_reg == ST_PV || state_reg == ST_Q));
    assign last     = (cnt_reg == CNT_W'(5));
    assign ia       = term ? c2 : c1;
    assign ib       = term ? c1 : c2;

    always_comb begin
        case (comp)
            2'd0:    begin c1 = 2'd1; c2 = 2'd2; end
            2'd1:    begin c1 = 2'd2; c2 = 2'd0; end
            default: begin c1 = 2'd0; c2 = 2'd1; end
        endcase
    end

    // operand select: cross terms use two narrow values, dot terms split the
    // wide cross component into a low unsigned and a high signed half
    always_comb begin
        a_op     = '0;
        b_op     = '0;
        wsel     = '0;
        shift_hi = 1'b0;
        neg      = 1'b0;
        case (state_reg)
            ST_PV: begin
                a_op = S_W'(d_reg[ia]);
                b_op = MB_W'(e2_reg[ib]);
                neg  = term;
            end
            ST_Q: begin
                a_op = s_reg[ia];
                b_op = MB_W'(e1_reg[ib]);
                neg  = term;
            end
            ST_DET: begin
                a_op = S_W'(e1_reg[comp]);
                wsel = pv_reg[comp];
            end
            ST_UN: begin
                a_op = s_reg[comp];
                wsel = pv_reg[comp];
                neg  = det_reg[ACC_W-1];
            end
            ST_VN: begin
                a_op = S_W'(d_reg[comp]);
                wsel = q_reg[comp];
                neg  = det_reg[ACC_W-1];
            end
            ST_TN: begin
                a_op = S_W'(e2_reg[comp]);
                wsel = q_reg[comp];
                neg  = det_reg[ACC_W-1];
            end
            default: begin
                a_op = '0;
            end
        endcase
        if (state_reg == ST_DET || state_reg == ST_UN ||
            state_reg == ST_VN || state_reg == ST_TN) begin
            shift_hi = term;
            b_op = term ? {wsel[WIDE_W-1], wsel[WIDE_W-1:S_W]}
                        : {1'b0, wsel[S_W-1:0]};
        end
    end

    assign prod     = a_op * b_op;
    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    assign mac_term = shift_hi ? (prod_ext << S_W) : prod_ext;
    assign acc_base = first ? '0 : acc_reg;

    assign div_shift = {rem_reg, num_reg[LIM_W-1]};
    assign div_trial = div_shift - {1'b0, det_reg};
    assign div_ge    = !div_trial[ACC_W];
    assign rem_step  = div_ge ? div_trial[ACC_W-1:0] : div_shift[ACC_W-1:0];
    assign quo_step  = {quo_reg[LIM_W-2:0], div_ge};

    assign uv_sum = {1'b0, un_reg} + {1'b0, vn_reg};
    assign det_sh = {det_reg, 16'h0000};
    assign checks_ok = (det_reg != '0) && (det_reg >= {32'h0, eps_reg}) &&
                       !un_reg[ACC_W-1] && !vn_reg[ACC_W-1] &&
                       (uv_sum <= {1'b0, det_reg}) &&
                       !tn_reg[ACC_W-1] && (tn_reg != '0) &&
                       ({16'h0000, tn_reg} < det_sh);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        o_next         = o_reg;
        d_next         = d_reg;
        lim_start_next = lim_start_reg;
        eps_next       = eps_reg;
        nearest_next   = nearest_reg;
        m_valid_next   = m_valid_reg;
        e1_next        = e1_reg;
        e2_next        = e2_reg;
        s_next         = s_reg;
        pv_next        = pv_reg;
        q_next         = q_reg;
        id_next        = id_reg;
        acc_next       = acc_reg;
        det_next       = det_reg;
        un_next        = un_reg;
        vn_next        = vn_reg;
        tn_next        = tn_reg;
        rem_next       = rem_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        hit_next       = hit_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        m_data_next    = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_index)
                CFG_ORIGIN_X: o_next[0] = cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Y: o_next[1] = cfg_data[COORD_W-1:0];
                CFG_ORIGIN_Z: o_next[2] = cfg_data[COORD_W-1:0];
                CFG_DIR_X:    d_next[0] = cfg_data[COORD_W-1:0];
                CFG_DIR_Y:    d_next[1] = cfg_data[COORD_W-1:0];
                CFG_DIR_Z:    d_next[2] = cfg_data[COORD_W-1:0];
                CFG_LIMIT:    lim_start_next = cfg_data[LIM_W-1:0];
                CFG_EPS:      eps_next = cfg_data[EPS_W-1:0];
                default:      eps_next = eps_reg;
            endcase
        end

        if (state_reg != ST_IDLE && state_reg != ST_ABS &&
            state_reg != ST_CHECK && state_reg != ST_DONE &&
            state_reg != ST_DIV_T && state_reg != ST_DIV_U &&
            state_reg != ST_DIV_V) begin
            acc_next = neg ? acc_base - mac_term : acc_base + mac_term;
            cnt_next = last ? '0 : cnt_reg + CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tdata[0]) begin
                        nearest_next = lim_start_reg;
                    end
                    for (int i = 0; i < 3; i++) begin
                        s_next[i]  = S_W'(o_reg[i]) -
                                     S_W'($signed(s_tdata[1+COORD_W*i +: COORD_W]));
                        e1_next[i] = s_tdata[1+COORD_W*(3+i) +: COORD_W];
                        e2_next[i] = s_tdata[1+COORD_W*(6+i) +: COORD_W];
                    end
                    id_next  = s_tdata[1+COORD_W*9 +: ID_W];
                    hit_next = 1'b0;
                    t_next   = '0;
                    u_next   = '0;
                    v_next   = '0;
                    cnt_next = '0;
                    state_next = ST_PV;
                end
            end
            ST_PV: begin
                if (term) pv_next[comp] = WIDE_W'(acc_next);
                if (last) state_next = ST_Q;
            end
            ST_Q: begin
                if (term) q_next[comp] = WIDE_W'(acc_next);
                if (last) state_next = ST_DET;
            end
            ST_DET: begin
                if (last) begin
                    det_next   = acc_next;
                    state_next = ST_UN;
                end
            end
            ST_UN: begin
                if (last) begin
                    un_next    = acc_next;
                    state_next = ST_VN;
                end
            end
            ST_VN: begin
                if (last) begin
                    vn_next    = acc_next;
                    state_next = ST_TN;
                end
            end
            ST_TN: begin
                if (last) begin
                    tn_next    = acc_next;
                    state_next = ST_ABS;
                end
            end
            ST_ABS: begin
                if (det_reg[ACC_W-1]) det_next = '0 - det_reg;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                // t quotient fits 32 bits here, so start from tn >> 16
                rem_next = tn_reg >> 16;
                num_next = {tn_reg[15:0], 16'h0000};
                quo_next = '0;
                cnt_next = '0;
                state_next = checks_ok ? ST_DIV_T : ST_DONE;
            end
            ST_DIV_T: begin
                rem_next = rem_step;
                num_next = num_reg << 1;
                quo_next = quo_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(LIM_W-1)) begin
                    cnt_next = '0;
                    if (quo_step < nearest_reg) begin
                        hit_next = 1'b1;
                        t_next   = quo_step;
                        rem_next = un_reg >> 1;
                        num_next = {un_reg[0], 31'h0};
                        quo_next = '0;
                        state_next = ST_DIV_U;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV_U: begin
                rem_next = rem_step;
                num_next = num_reg << 1;
                quo_next = quo_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(UV_W-1)) begin
                    cnt_next = '0;
                    u_next   = quo_step[UV_W-1:0];
                    rem_next = vn_reg >> 1;
                    num_next = {vn_reg[0], 31'h0};
                    quo_next = '0;
                    state_next = ST_DIV_V;
                end
            end
            ST_DIV_V: begin
                rem_next = rem_step;
                num_next = num_reg << 1;
                quo_next = quo_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(UV_W-1)) begin
                    cnt_next = '0;
                    v_next   = quo_step[UV_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    if (hit_reg) nearest_next = t_reg;
                    m_data_next = {5'b00000, (hit_reg ? t_reg : nearest_reg), id_reg,
                                   v_reg, u_reg, t_reg, hit_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            o_reg         <= '{default: '0};
            d_reg         <= '{default: '0};
            lim_start_reg <= '1;
            eps_reg       <= EPS_RESET;
            nearest_reg   <= '1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            o_reg         <= o_next;
            d_reg         <= d_next;
            lim_start_reg <= lim_start_next;
            eps_reg       <= eps_next;
            nearest_reg   <= nearest_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        e1_reg     <= e1_next;
        e2_reg     <= e2_next;
        s_reg      <= s_next;
        pv_reg     <= pv_next;
        q_reg      <= q_next;
        id_reg     <= id_next;
        acc_reg    <= acc_next;
        det_reg    <= det_next;
        un_reg     <= un_next;
        vn_reg     <= vn_next;
        tn_reg     <= tn_next;
        rem_reg    <= rem_next;
        num_reg    <= num_next;
        quo_reg    <= quo_next;
        hit_reg    <= hit_next;
        t_reg      <= t_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    a_hit_sets_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[114:83] == m_tdata[32:1]))
        else $error("hit limit differs from t");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[66:1] == '0))
        else $error("miss carries nonzero t/u/v");

    a_bary_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |->
        (({1'b0, m_tdata[49:33]} + {1'b0, m_tdata[66:50]}) <= 18'd65536))
        else $error("u + v above one");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item taken while busy");
`endif

endmodule

[tb/tb_ray_triangle_intersect.sv]
`timescale 1ns / 1ps

module tb_ray_triangle_intersect;
    import rti_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic              hit;
        logic [LIM_W-1:0]  t_hit;
        logic [UV_W-1:0]   u_bary;
        logic [UV_W-1:0]   v_bary;
        logic [ID_W-1:0]   hit_id;
        logic [LIM_W-1:0]  limit_now;
    } hit_report_t;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd12;
    localparam longint CYCLE_LIMIT = 1000000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ray_triangle_intersect dut (.*);

    // predictor copy of the ray registers and the nearest limit
    logic [COORD_W-1:0] ray_org [3];
    logic [COORD_W-1:0] ray_dir [3];
    logic [LIM_W-1:0]   limit_reload;
    logic [EPS_W-1:0]   det_floor;
    logic [LIM_W-1:0]   nearest_t;

    // stimulus-side view of the ray, used to aim triangles
    longint aim_org [3];
    longint aim_dir [3];

    logic [IN_W-1:0] tri_queue [$];
    hit_report_t     hits_due [$];
    logic            tri_taken;
    bit              steady;
    int              cfg_count;
    int              fail_count;
    longint          cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic wide_t sext(logic [COORD_W-1:0] f);
        return wide_t'($signed(f));
    endfunction

    function automatic hit_report_t test_triangle(logic [IN_W-1:0] item);
        wide_t o[3], d[3], p[3], e1[3], e2[3], s[3], pv[3], q[3];
        wide_t det, un, vn, tn, quo;
        hit_report_t r;
        if (item[0])
            nearest_t = limit_reload;
        for (int k = 0; k < 3; k++) begin
            o[k]  = sext(ray_org[k]);
            d[k]  = sext(ray_dir[k]);
            p[k]  = sext(item[1 + 24*k +: 24]);
            e1[k] = sext(item[73 + 24*k +: 24]);
            e2[k] = sext(item[145 + 24*k +: 24]);
            s[k]  = o[k] - p[k];
        end
        pv[0] = d[1]*e2[2] - d[2]*e2[1];
        pv[1] = d[2]*e2[0] - d[0]*e2[2];
        pv[2] = d[0]*e2[1] - d[1]*e2[0];
        q[0]  = s[1]*e1[2] - s[2]*e1[1];
        q[1]  = s[2]*e1[0] - s[0]*e1[2];
        q[2]  = s[0]*e1[1] - s[1]*e1[0];
        det = e1[0]*pv[0] + e1[1]*pv[1] + e1[2]*pv[2];
        un  = s[0]*pv[0] + s[1]*pv[1] + s[2]*pv[2];
        vn  = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
        tn  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
        if (det < 0) begin
            det = -det; un = -un; vn = -vn; tn = -tn;
        end
        r.hit = det != 0 && det >= wide_t'({80'd0, det_floor}) && un >= 0 && vn >= 0
            && un + vn <= det && tn > 0
            && (tn <<< 16) < wide_t'({96'd0, nearest_t}) * det;
        r.t_hit  = '0;
        r.u_bary = '0;
        r.v_bary = '0;
        if (r.hit) begin
            quo = (tn <<< 16) / det;
            r.t_hit = quo > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : quo[31:0];
            quo = (un <<< 16) / det;
            r.u_bary = quo > 65536 ? 17'd65536 : quo[16:0];
            quo = (vn <<< 16) / det;
            r.v_bary = quo > 65536 ? 17'd65536 : quo[16:0];
            nearest_t = r.t_hit;
        end
        r.hit_id = item[217 +: 16];
        r.limit_now = nearest_t;
        return r;
    endfunction

    function automatic longint rand_pm(longint m);
        return longint'($urandom_range(0, 2*m)) - m;
    endfunction

    function automatic logic [IN_W-1:0] pack_tri(bit nr, longint p[3], longint a[3],
                                                 longint b[3], logic [15:0] id);
        logic [IN_W-1:0] w;
        w = '0;
        w[0] = nr;
        for (int k = 0; k < 3; k++) begin
            w[1 + 24*k +: 24]   = p[k][23:0];
            w[73 + 24*k +: 24]  = a[k][23:0];
            w[145 + 24*k +: 24] = b[k][23:0];
        end
        w[217 +: 16] = id;
        return w;
    endfunction

    // triangle placed so the ray meets its plane at t = tr / 2^tsh with
    // barycentrics ur/256, vr/256 (negative ur picks a random inside point)
    function automatic logic [IN_W-1:0] aimed_tri(bit nr, longint tr, int tsh, int ur,
                                                  int vr, longint emag);
        longint p[3], a[3], b[3];
        if (ur < 0) begin
            ur = $urandom_range(0, 256);
            vr = $urandom_range(0, 256 - ur);
        end
        for (int k = 0; k < 3; k++) begin
            a[k] = rand_pm(emag);
            b[k] = rand_pm(emag);
            p[k] = aim_org[k] + ((aim_dir[k] * tr) >>> tsh)
                - ((ur * a[k]) >>> 8) - ((vr * b[k]) >>> 8);
        end
        return pack_tri(nr, p, a, b, 16'($urandom));
    endfunction

    function automatic logic [IN_W-1:0] noise_tri();
        logic [IN_W-1:0] w;
        for (int k = 0; k < IN_W; k += 16)
            w[k +: 16] = 16'($urandom);
        w[IN_W-1:233] = '0;
        return w;
    endfunction

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || tri_taken) begin
            if (tri_queue.size() > 0 && (steady || $urandom_range(0, 99) >= 29)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= tri_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && (steady || $urandom_range(0, 99) >= 29);
    end

    // monitor, predictor and checker
    always @(posedge aclk) begin
        hit_report_t want, got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("FAIL ray_triangle_intersect");
            $finish;
        end
        tri_taken <= s_tvalid && s_tready && aresetn;
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                ray_org[k] = '0;
                ray_dir[k] = '0;
            end
            limit_reload = '1;
            det_floor = EPS_RESET;
            nearest_t = '1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z: begin
                        ray_org[2'(cfg_index - CFG_ORIGIN_X)] = cfg_data[COORD_W-1:0];
                    end
                    CFG_DIR_X, CFG_DIR_Y, CFG_DIR_Z: begin
                        ray_dir[2'(cfg_index - CFG_DIR_X)] = cfg_data[COORD_W-1:0];
                    end
                    CFG_LIMIT: limit_reload = cfg_data[LIM_W-1:0];
                    CFG_EPS:   det_floor = cfg_data[EPS_W-1:0];
                    default: ;
                endcase
                cfg_count <= cfg_count + 1;
            end
            if (s_tvalid && s_tready)
                hits_due.push_back(test_triangle(s_tdata));
            if (m_tvalid && m_tready) begin
                got.hit       = m_tdata[0];
                got.t_hit     = m_tdata[32:1];
                got.u_bary    = m_tdata[49:33];
                got.v_bary    = m_tdata[66:50];
                got.hit_id    = m_tdata[82:67];
                got.limit_now = m_tdata[114:83];
                if (hits_due.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = hits_due.pop_front();
                    if (got.hit !== want.hit) begin
                        $display("%0t: hit exp %b act %b", $time, want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.t_hit !== want.t_hit) begin
                        $display("%0t: t_hit exp %h act %h", $time, want.t_hit, got.t_hit);
                        fail_count++;
                    end
                    if (got.u_bary !== want.u_bary) begin
                        $display("%0t: u_bary exp %h act %h", $time, want.u_bary,
                                 got.u_bary);
                        fail_count++;
                    end
                    if (got.v_bary !== want.v_bary) begin
                        $display("%0t: v_bary exp %h act %h", $time, want.v_bary,
                                 got.v_bary);
                        fail_count++;
                    end
                    if (got.hit_id !== want.hit_id) begin
                        $display("%0t: hit_id exp %h act %h", $time, want.hit_id,
                                 got.hit_id);
                        fail_count++;
                    end
                    if (got.limit_now !== want.limit_now) begin
                        $display("%0t: limit_now exp %h act %h", $time, want.limit_now,
                                 got.limit_now);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        int seen;
        seen = cfg_count;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        wait (cfg_count != seen);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_ray(longint o[3], longint d[3], longint lim, longint eps);
        for (int k = 0; k < 3; k++) begin
            write_reg(CFG_ORIGIN_X + CFG_IDX_W'(k), o[k]);
            write_reg(CFG_DIR_X + CFG_IDX_W'(k), d[k]);
            aim_org[k] = o[k];
            aim_dir[k] = d[k];
        end
        write_reg(CFG_LIMIT, lim);
        write_reg(CFG_EPS, eps);
    endtask

    // sender holds off until every result is back, then the block settles
    task automatic drain();
        do @(posedge aclk);
        while (tri_queue.size() != 0 || s_tvalid || hits_due.size() != 0);
        repeat (150) @(posedge aclk);
    endtask

    initial begin
        longint o[3], d[3], p[3], a[3], b[3], lim, eps;
        int pick;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        tri_taken = 1'b0;
        steady    = 1'b0;
        cfg_count = 0;
        fail_count = 0;
        cycles    = 0;
        for (int k = 0; k < 3; k++) begin
            aim_org[k] = 0;
            aim_dir[k] = 0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset registers: zero direction, every test misses
        tri_queue.push_back(noise_tri());
        tri_queue.push_back(aimed_tri(1'b1, 256, 8, -1, 0, 1 << 18));
        drain();

        o = '{0, 0, 0};
        d = '{0, 0, 4096};
        set_ray(o, d, 64'hFFFF_FFFF, 0);
        write_reg(CFG_UNUSED, 48'hFFFF_FFFF_FFFF);
        for (int k = 0; k < 3; k++) begin
            p[k] = 24'h7FFFFF; a[k] = 24'h7FFFFF; b[k] = 24'h7FFFFF;
        end
        tri_queue.push_back(pack_tri(1'b1, p, a, b, 16'hFFFF));
        for (int k = 0; k < 3; k++) begin
            p[k] = -(1 << 23); a[k] = -(1 << 23); b[k] = 1 << 20;
        end
        tri_queue.push_back(pack_tri(1'b0, p, a, b, 16'h0000));
        // flat triangle: edges parallel, determinant zero even with no floor
        for (int k = 0; k < 3; k++) begin
            p[k] = rand_pm(1 << 16); a[k] = rand_pm(1 << 16); b[k] = 2 * a[k];
        end
        tri_queue.push_back(pack_tri(1'b0, p, a, b, 16'h1234));
        tri_queue.push_back(aimed_tri(1'b0, 1024, 8, -1, 0, 1 << 18));
        tri_queue.push_back(aimed_tri(1'b0, 512, 8, -1, 0, 1 << 18));
        tri_queue.push_back(aimed_tri(1'b0, 2048, 8, -1, 0, 1 << 18));
        tri_queue.push_back(aimed_tri(1'b0, -512, 8, -1, 0, 1 << 18));
        tri_queue.push_back(aimed_tri(1'b0, 256, 8, 200, 200, 1 << 18));
        tri_queue.push_back(aimed_tri(1'b0, 256, 8, 128, 128, 1 << 18));
        tri_queue.push_back(aimed_tri(1'b1, 256, 8, 0, 0, 1 << 18));
        tri_queue.push_back(aimed_tri(1'b1, 256, 8, 256, 0, 1 << 18));
        drain();

        // hit closer than one limit step drives the limit to zero
        d = '{0, 0, 1 << 20};
        set_ray(o, d, 64'h0001_0000, 687);
        tri_queue.push_back(aimed_tri(1'b1, 1, 18, -1, 0, 1 << 18));
        tri_queue.push_back(aimed_tri(1'b0, 1, 10, -1, 0, 1 << 18));
        tri_queue.push_back(aimed_tri(1'b1, 1, 18, -1, 0, 1 << 18));
        tri_queue.push_back(aimed_tri(1'b1, 1, 10, -1, 0, 1 << 18));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            steady = (ph == 2);
            for (int k = 0; k < 3; k++) begin
                o[k] = rand_pm(1 << 20);
                d[k] = rand_pm(1 << 16);
            end
            if (ph == 3) begin
                o = '{-(1 << 23), (1 << 23) - 1, -(1 << 23)};
                d = '{(1 << 23) - 1, -(1 << 23), 4096};
            end
            case (ph % 4)
                0: lim = 64'hFFFF_FFFF;
                1: lim = 0;
                default: lim = $urandom;
            endcase
            case (ph)
                1: eps = 48'hFFFF_FFFF_FFFF;
                4: eps = 0;
                5: eps = 687;
                default: eps = {$urandom_range(0, 65535), $urandom};
            endcase
            set_ray(o, d, lim, eps);
            for (int n = 0; n < 100; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    tri_queue.push_back(aimed_tri($urandom_range(0, 4) == 0,
                        longint'($urandom_range(0, 4200)) - 100, 8, -1, 0, 1 << 18));
                else if (pick < 90)
                    tri_queue.push_back(noise_tri());
                else begin
                    for (int k = 0; k < 3; k++) begin
                        p[k] = rand_pm(1 << 22); a[k] = rand_pm(1 << 20); b[k] = -a[k];
                    end
                    tri_queue.push_back(pack_tri($urandom_range(0, 1), p, a, b,
                                                 16'($urandom)));
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("PASS ray_triangle_intersect");
        else
            $display("FAIL ray_triangle_intersect");
        $finish;
    end

endmodule
